[design/gmb_pkg.sv]
package gmb_pkg;

  // Grid and stack geometry.
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STACK_DEPTH = 1024;
  localparam int MIN_DIM     = 5;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int GRID_AW  = COL_W + ROW_W;
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
  localparam int DIM_W    = 7;
  localparam int POS_W    = COL_W + ROW_W;

  // Item modes.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  // Result actions.
  localparam logic [1:0] ACT_ACK      = 2'd0;
  localparam logic [1:0] ACT_ADVANCE  = 2'd1;
  localparam logic [1:0] ACT_BACK     = 2'd2;
  localparam logic [1:0] ACT_FINISHED = 2'd3;

  // Probe directions.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

endpackage

[design/grid_maze_backtracker.sv]
// Write, read, start and empty-stack step items go straight to the result register; a step on a
// non-empty stack first runs the four neighbor probes, which share the single grid read port,
// then decides, and reads the new top through S_POP when it backs up and leaves entries behind.
// A new item is taken only once the result of the last one is loaded; in_stall is high until then.
// Reset (rst, synchronous): control state clears and a clearing pass writes every grid cell to
// wall; in_stall stays high during that pass, while configuration writes are taken as usual.
module grid_maze_backtracker
  import gmb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic [COL_W-1:0]    pos_col,
  input  logic [ROW_W-1:0]    pos_row,
  input  logic                cell_in,
  input  logic [1:0]          pick,
  // Output channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic                cell_out,
  output logic [1:0]          action,
  output logic [COL_W-1:0]    top_col,
  output logic [ROW_W-1:0]    top_row,
  output logic [DEPTH_W-1:0]  depth_out
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DECIDE,
    S_POP,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [DIM_W-1:0] width_in_use;
  logic [DIM_W-1:0] height_in_use;

  // Walk state and the item in work.
  logic [DEPTH_W-1:0] stack_count;
  logic [COL_W-1:0]   walk_col;
  logic [ROW_W-1:0]   walk_row;
  logic [1:0]         item_mode;
  logic [1:0]         item_pick;
  logic [1:0]         res_action;
  logic [2:0]         probe_k;
  logic [3:0]         open_bits;
  logic [GRID_AW-1:0] clr_addr;

  // Grid memory, one bit per cell.
  logic               grid [2**GRID_AW];
  logic               grid_we;
  logic [GRID_AW-1:0] grid_waddr;
  logic               grid_wdata;
  logic               grid_re;
  logic [GRID_AW-1:0] grid_raddr;
  logic               grid_rdata;

  // Stack memory, {row, col} per entry.
  logic [POS_W-1:0]    path_stack [STACK_DEPTH];
  logic                stack_we;
  logic [STACK_AW-1:0] stack_waddr;
  logic [POS_W-1:0]    stack_wdata;
  logic                stack_re;
  logic [STACK_AW-1:0] stack_raddr;
  logic [POS_W-1:0]    stack_rdata;

  logic                accept;
  logic                out_free;
  logic [7:0]          dim_w;
  logic [7:0]          dim_h;
  logic [7:0]          c8;
  logic [7:0]          r8;
  logic                col_ok;
  logic                row_ok;
  logic [3:0]          inb;
  logic [COL_W-1:0]    tgt_col [4];
  logic [ROW_W-1:0]    tgt_row [4];
  logic [COL_W-1:0]    mid_col [4];
  logic [ROW_W-1:0]    mid_row [4];
  logic [1:0]          probe_dir;
  logic [1:0]          prev_dir;
  logic [1:0]          dir_sel;
  logic                advance;
  logic [DEPTH_W-1:0]  count_less2;

  // Reduce pick modulo the number of open directions.
  function automatic logic [1:0] pick_mod(input logic [1:0] p, input logic [2:0] n);
    logic [1:0] r;
    case (n)
      3'd1: begin
        r = 2'd0;
      end
      3'd2: begin
        r = {1'b0, p[0]};
      end
      3'd3: begin
        r = (p == 2'd3) ? 2'd0 : p;
      end
      default: begin
        r = p;
      end
    endcase
    return r;
  endfunction

  // Return the direction of the idx-th open direction, counting up, right, down, left.
  function automatic logic [1:0] choose_dir(input logic [3:0] open, input logic [1:0] idx);
    logic [1:0] seen;
    logic [1:0] dir;
    seen = 2'd0;
    dir  = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (open[d]) begin
        if (seen == idx) dir = 2'(d);
        seen = seen + 2'd1;
      end
    end
    return dir;
  endfunction

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Register reads return the stored value.
  always_comb begin
    if (paddr[2] == REG_HEIGHT) prdata = {{(32-DIM_W){1'b0}}, height_in_use};
    else prdata = {{(32-DIM_W){1'b0}}, width_in_use};
  end

  // Dimensions in use, held to the legal range.
  always_comb begin
    if (width_in_use < DIM_W'(MIN_DIM)) dim_w = 8'(MIN_DIM);
    else if (width_in_use > DIM_W'(MAX_WIDTH)) dim_w = 8'(MAX_WIDTH);
    else dim_w = {1'b0, width_in_use};
    if (height_in_use < DIM_W'(MIN_DIM)) dim_h = 8'(MIN_DIM);
    else if (height_in_use > DIM_W'(MAX_HEIGHT)) dim_h = 8'(MAX_HEIGHT);
    else dim_h = {1'b0, height_in_use};
  end

  // Targets two cells away, the cells between, and the border test for each direction.
  always_comb begin
    c8 = {{(8-COL_W){1'b0}}, walk_col};
    r8 = {{(8-ROW_W){1'b0}}, walk_row};
    col_ok = (c8 >= 8'd1) && (c8 + 8'd2 <= dim_w);
    row_ok = (r8 >= 8'd1) && (r8 + 8'd2 <= dim_h);
    inb[DIR_UP]    = col_ok && (r8 >= 8'd3) && (r8 <= dim_h);
    inb[DIR_RIGHT] = row_ok && (c8 + 8'd4 <= dim_w);
    inb[DIR_DOWN]  = col_ok && (r8 + 8'd4 <= dim_h);
    inb[DIR_LEFT]  = row_ok && (c8 >= 8'd3) && (c8 <= dim_w);

    tgt_col[DIR_UP]    = walk_col;
    tgt_row[DIR_UP]    = walk_row - ROW_W'(2);
    tgt_col[DIR_RIGHT] = walk_col + COL_W'(2);
    tgt_row[DIR_RIGHT] = walk_row;
    tgt_col[DIR_DOWN]  = walk_col;
    tgt_row[DIR_DOWN]  = walk_row + ROW_W'(2);
    tgt_col[DIR_LEFT]  = walk_col - COL_W'(2);
    tgt_row[DIR_LEFT]  = walk_row;

    mid_col[DIR_UP]    = walk_col;
    mid_row[DIR_UP]    = walk_row - ROW_W'(1);
    mid_col[DIR_RIGHT] = walk_col + COL_W'(1);
    mid_row[DIR_RIGHT] = walk_row;
    mid_col[DIR_DOWN]  = walk_col;
    mid_row[DIR_DOWN]  = walk_row + ROW_W'(1);
    mid_col[DIR_LEFT]  = walk_col - COL_W'(1);
    mid_row[DIR_LEFT]  = walk_row;
  end

  // Choice of direction once all four probes are in.
  assign probe_dir   = probe_k[1:0];
  assign prev_dir    = probe_dir - 2'd1;
  assign dir_sel     = choose_dir(open_bits, pick_mod(item_pick, 3'($countones(open_bits))));
  assign advance     = (open_bits != 4'd0) && (stack_count < DEPTH_W'(STACK_DEPTH));
  assign count_less2 = stack_count - DEPTH_W'(2);

  // Grid port control.
  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = {walk_row, walk_col};
    grid_wdata = 1'b1;
    grid_re    = 1'b0;
    grid_raddr = {pos_row, pos_col};
    case (state)
      S_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_addr;
        grid_wdata = 1'b0;
      end
      S_IDLE: begin
        grid_we    = accept && (mode == MODE_WRITE);
        grid_waddr = {pos_row, pos_col};
        grid_wdata = cell_in;
        grid_re    = accept && (mode == MODE_READ);
      end
      S_PROBE: begin
        grid_we    = (probe_k == 3'd0);
        grid_re    = (probe_k < 3'd4);
        grid_raddr = {tgt_row[probe_dir], tgt_col[probe_dir]};
      end
      S_DECIDE: begin
        grid_we    = advance;
        grid_waddr = {mid_row[dir_sel], mid_col[dir_sel]};
      end
      default: begin
      end
    endcase
  end

  // Stack port control.
  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = stack_count[STACK_AW-1:0];
    stack_wdata = {pos_row, pos_col};
    stack_re    = 1'b0;
    stack_raddr = count_less2[STACK_AW-1:0];
    case (state)
      S_IDLE: begin
        stack_we    = accept && (mode == MODE_START);
        stack_waddr = '0;
      end
      S_DECIDE: begin
        stack_we    = advance;
        stack_wdata = {tgt_row[dir_sel], tgt_col[dir_sel]};
        stack_re    = !advance && (stack_count >= DEPTH_W'(2));
      end
      default: begin
      end
    endcase
  end

  // Grid memory.
  always_ff @(posedge clk) begin
    if (grid_we) grid[grid_waddr] <= grid_wdata;
    if (grid_re) grid_rdata <= grid[grid_raddr];
  end

  // Stack memory.
  always_ff @(posedge clk) begin
    if (stack_we) path_stack[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rdata <= path_stack[stack_raddr];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= DIM_W'(MAX_WIDTH);
      height_in_use <= DIM_W'(MAX_HEIGHT);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HEIGHT) height_in_use <= pwdata[DIM_W-1:0];
      else width_in_use <= pwdata[DIM_W-1:0];
    end
  end

  // Sequencer, walk state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      stack_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // A taken result leaves the register empty unless a new one is loaded below.
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + GRID_AW'(1);
          if (clr_addr == {GRID_AW{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            item_mode <= mode;
            item_pick <= pick;
            probe_k   <= 3'd0;
            if (mode == MODE_START) begin
              stack_count <= DEPTH_W'(1);
              walk_col    <= pos_col;
              walk_row    <= pos_row;
            end
            // A step on a non-empty stack goes on to probe; everything else answers at once.
            if ((mode == MODE_STEP) && (stack_count != '0)) begin
              res_action <= ACT_ACK;
              state      <= S_PROBE;
            end else begin
              res_action <= (mode == MODE_STEP) ? ACT_FINISHED : ACT_ACK;
              state      <= S_DONE;
            end
          end
        end
        S_PROBE: begin
          // Read data of the previous probe is in; wall means the target is still open.
          if (probe_k != 3'd0) open_bits[prev_dir] <= inb[prev_dir] && !grid_rdata;
          probe_k <= probe_k + 3'd1;
          if (probe_k == 3'd4) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (advance) begin
            stack_count <= stack_count + DEPTH_W'(1);
            walk_col    <= tgt_col[dir_sel];
            walk_row    <= tgt_row[dir_sel];
            res_action  <= ACT_ADVANCE;
            state       <= S_DONE;
          end else begin
            stack_count <= stack_count - DEPTH_W'(1);
            res_action  <= ACT_BACK;
            state       <= (stack_count >= DEPTH_W'(2)) ? S_POP : S_DONE;
          end
        end
        S_POP: begin
          walk_col <= stack_rdata[COL_W-1:0];
          walk_row <= stack_rdata[POS_W-1:COL_W];
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            cell_out  <= (item_mode == MODE_READ) ? grid_rdata : 1'b0;
            action    <= res_action;
            depth_out <= stack_count;
            top_col   <= (stack_count == '0) ? '0 : walk_col;
            top_row   <= (stack_count == '0) ? '0 : walk_row;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The stack never reports more entries than it holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (depth_out <= DEPTH_W'(STACK_DEPTH)))
    else $error("stack depth beyond capacity");

  // A finished walk leaves an empty stack; an advance leaves at least two entries.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_FINISHED) |-> (depth_out == '0))
    else $error("finished walk with entries on the stack");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_ADVANCE) |-> (depth_out >= DEPTH_W'(2)))
    else $error("advance with fewer than two stack entries");

  // A grid write and a grid read in one cycle never touch the same cell.
  assert property (@(posedge clk) disable iff (rst)
    grid_we && grid_re |-> (grid_waddr != grid_raddr))
    else $error("grid read and write collide");

  // No result appears while the clearing pass runs.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result during grid clearing pass");
`endif

endmodule
